@@ design/quad_dac_register_shadow_defines.svh @@
// assertion macros shared by the quad dac register shadow rtl
// expects clk and arst_n in the scope of every use
`ifndef QUAD_DAC_REGISTER_SHADOW_DEFINES_SVH
`define QUAD_DAC_REGISTER_SHADOW_DEFINES_SVH

// condition holds at every clock edge out of reset
`define QDRS_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// antecedent in a cycle implies consequent in the same cycle
`define QDRS_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ design/qdrs_pkg.sv @@
// types, codes and constants of the quad dac register shadow
// no dependencies; used by every module of the block
package qdrs_pkg;

	localparam int NUM_CH = 4;
	localparam int CH_W = 2;
	localparam int CODE_W = 12;
	localparam int VOLT_W = 23;
	localparam int SEL_W = 8;
	localparam int FUNC_W = 3;
	localparam int PD_W = 2;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [VOLT_W-1:0] VREF_RESET_UV = 23'd3300000;
	// internal 2.048 v reference over 4096 steps
	localparam logic [8:0] INT_LSB_UV = 9'd500;
	localparam logic [0:0] REG_EXT_VREF = 1'b0;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_WRITE_VOL = 3'd0,
		FUNC_WRITE_EE  = 3'd1,
		FUNC_VREF      = 3'd2,
		FUNC_GAIN      = 3'd3,
		FUNC_PWRDN     = 3'd4,
		FUNC_IGNORE    = 3'd5
	} func_e;

	typedef enum logic {
		FR_IDLE,
		FR_GLOBAL
	} front_state_e;

	typedef struct packed {
		logic            vref_int;
		logic [PD_W-1:0] pd;
		logic            gain;
	} settings_t;

	typedef struct packed {
		logic [CH_W-1:0]   channel;
		settings_t         settings;
		logic [CODE_W-1:0] code;
		logic [CODE_W-1:0] ecode;
		logic              ignored;
		logic              last;
	} report_t;

endpackage

@@ design/qdrs_front.sv @@
// command front end: register state, command decode, report expansion
// depends on qdrs_pkg
module qdrs_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  logic [qdrs_pkg::FUNC_W-1:0]   func,
	input  logic [qdrs_pkg::CH_W-1:0]     channel,
	input  logic [qdrs_pkg::CODE_W-1:0]   code,
	input  logic [qdrs_pkg::SEL_W-1:0]    select_bits,
	input  logic                          q_full,
	output logic                          push,
	output qdrs_pkg::report_t             entry
);

	qdrs_pkg::front_state_e state_q, state_nx;
	qdrs_pkg::settings_t live_set_q [qdrs_pkg::NUM_CH];
	qdrs_pkg::settings_t new_set [qdrs_pkg::NUM_CH];
	logic [qdrs_pkg::CODE_W-1:0] live_code_q [qdrs_pkg::NUM_CH];
	logic [qdrs_pkg::CODE_W-1:0] stored_code_q [qdrs_pkg::NUM_CH];
	logic [qdrs_pkg::CH_W-1:0] idx_q;
	logic accept;
	logic idx_last;
	qdrs_pkg::func_e fn;

	assign fn = qdrs_pkg::func_e'(func);
	assign accept = cmd_valid && !cmd_stall;
	assign idx_last = (idx_q == qdrs_pkg::CH_W'(qdrs_pkg::NUM_CH - 1));

	// settings of all channels after a global command
	always_comb begin
		for (int i = 0; i < qdrs_pkg::NUM_CH; i++) begin
			new_set[i] = live_set_q[i];
			case (fn)
				qdrs_pkg::FUNC_VREF: begin
					new_set[i].vref_int = select_bits[qdrs_pkg::NUM_CH - 1 - i];
				end
				qdrs_pkg::FUNC_GAIN: begin
					new_set[i].gain = select_bits[qdrs_pkg::NUM_CH - 1 - i];
				end
				qdrs_pkg::FUNC_PWRDN: begin
					new_set[i].pd = select_bits[qdrs_pkg::SEL_W - 1 - 2*i -: qdrs_pkg::PD_W];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			qdrs_pkg::FR_IDLE: begin
				if (accept && (fn == qdrs_pkg::FUNC_VREF || fn == qdrs_pkg::FUNC_GAIN ||
						fn == qdrs_pkg::FUNC_PWRDN)) begin
					state_nx = qdrs_pkg::FR_GLOBAL;
				end
			end
			qdrs_pkg::FR_GLOBAL: begin
				if (!q_full && idx_last) begin
					state_nx = qdrs_pkg::FR_IDLE;
				end
			end
			default: state_nx = qdrs_pkg::FR_IDLE;
		endcase
	end

	always_comb begin
		push = 1'b0;
		entry = '0;
		cmd_stall = 1'b1;
		case (state_q)
			qdrs_pkg::FR_IDLE: begin
				cmd_stall = q_full;
				if (accept) begin
					push = 1'b1;
					case (fn)
						qdrs_pkg::FUNC_WRITE_VOL, qdrs_pkg::FUNC_WRITE_EE: begin
							entry.channel = channel;
							entry.settings = live_set_q[channel];
							entry.code = code;
							entry.ecode = (fn == qdrs_pkg::FUNC_WRITE_EE) ? code
								: stored_code_q[channel];
							entry.last = 1'b1;
						end
						qdrs_pkg::FUNC_VREF, qdrs_pkg::FUNC_GAIN, qdrs_pkg::FUNC_PWRDN: begin
							// channel a goes out in the accept cycle
							entry.channel = '0;
							entry.settings = new_set[0];
							entry.code = live_code_q[0];
							entry.ecode = stored_code_q[0];
						end
						default: begin
							entry.channel = channel;
							entry.settings = live_set_q[channel];
							entry.code = live_code_q[channel];
							entry.ecode = stored_code_q[channel];
							entry.ignored = 1'b1;
							entry.last = 1'b1;
						end
					endcase
				end
			end
			qdrs_pkg::FR_GLOBAL: begin
				push = !q_full;
				entry.channel = idx_q;
				entry.settings = live_set_q[idx_q];
				entry.code = live_code_q[idx_q];
				entry.ecode = stored_code_q[idx_q];
				entry.last = idx_last;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qdrs_pkg::FR_IDLE;
			idx_q <= '0;
			for (int i = 0; i < qdrs_pkg::NUM_CH; i++) begin
				live_set_q[i] <= '0;
				live_code_q[i] <= '0;
				stored_code_q[i] <= '0;
			end
		end else begin
			state_q <= state_nx;
			if (state_q == qdrs_pkg::FR_GLOBAL && push) begin
				idx_q <= idx_q + 1'b1;
			end
			if (accept) begin
				case (fn)
					qdrs_pkg::FUNC_WRITE_VOL: begin
						live_code_q[channel] <= code;
					end
					qdrs_pkg::FUNC_WRITE_EE: begin
						live_code_q[channel] <= code;
						stored_code_q[channel] <= code;
					end
					qdrs_pkg::FUNC_VREF, qdrs_pkg::FUNC_GAIN, qdrs_pkg::FUNC_PWRDN: begin
						live_set_q <= new_set;
						idx_q <= qdrs_pkg::CH_W'(1);
					end
					default: begin
					end
				endcase
			end
		end
	end

endmodule

@@ design/qdrs_queue.sv @@
// report queue between front end and voltage back end
// depends on qdrs_pkg and the assertion macro header
`include "quad_dac_register_shadow_defines.svh"

module qdrs_queue #(
	parameter int DEPTH = qdrs_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  qdrs_pkg::report_t wdata,
	output logic              full,
	input  logic              pop,
	output logic              nonempty,
	output qdrs_pkg::report_t rdata
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	qdrs_pkg::report_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full = (count_q == CW'(DEPTH));
	assign nonempty = (count_q != '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	`QDRS_ASSERT_IMPL(a_no_overflow, push, !full, "push into a full report queue")
	`QDRS_ASSERT_IMPL(a_no_underflow, pop, nonempty, "pop from an empty report queue")
	`QDRS_ASSERT_ALWAYS(a_count_range, count_q <= CW'(DEPTH), "report queue count out of range")

endmodule

@@ design/qdrs_back.sv @@
// voltage back end: multiply stage and output register
// depends on qdrs_pkg
module qdrs_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [qdrs_pkg::VOLT_W-1:0]   ext_vref_uv,
	input  logic                          q_nonempty,
	input  qdrs_pkg::report_t             head,
	output logic                          pop,
	output logic                          rpt_valid,
	input  logic                          rpt_stall,
	output qdrs_pkg::report_t             rpt,
	output logic [qdrs_pkg::VOLT_W-1:0]   voltage_uv
);

	localparam int PROD_W = qdrs_pkg::CODE_W + qdrs_pkg::VOLT_W;
	localparam int BASE_W = qdrs_pkg::CODE_W + 9;

	logic [PROD_W-1:0] ext_prod;
	logic [BASE_W-1:0] int_base;
	logic [qdrs_pkg::VOLT_W-1:0] int_volt;
	logic s1_valid_q, out_valid_q;
	logic s1_en, out_en;
	qdrs_pkg::report_t rpt_s1, rpt_q;
	logic [qdrs_pkg::VOLT_W-1:0] ext_v_s1, int_v_s1, volt_q;

	assign out_en = !out_valid_q || !rpt_stall;
	assign s1_en = !s1_valid_q || out_en;
	assign pop = q_nonempty && s1_en;

	assign ext_prod = PROD_W'(head.code) * PROD_W'(ext_vref_uv);
	assign int_base = BASE_W'(head.code) * BASE_W'(qdrs_pkg::INT_LSB_UV);
	assign int_volt = head.settings.gain ? qdrs_pkg::VOLT_W'({int_base, 1'b0})
		: qdrs_pkg::VOLT_W'(int_base);

	always_ff @(posedge clk) begin
		if (pop) begin
			rpt_s1 <= head;
			ext_v_s1 <= ext_prod[PROD_W-1 -: qdrs_pkg::VOLT_W];
			int_v_s1 <= int_volt;
		end
		if (out_en && s1_valid_q) begin
			rpt_q <= rpt_s1;
			if (rpt_s1.settings.pd != '0) begin
				volt_q <= '0;
			end else if (rpt_s1.settings.vref_int) begin
				volt_q <= int_v_s1;
			end else begin
				volt_q <= ext_v_s1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_en) begin
				s1_valid_q <= q_nonempty;
			end
			if (out_en) begin
				out_valid_q <= s1_valid_q;
			end
		end
	end

	assign rpt_valid = out_valid_q;
	assign rpt = rpt_q;
	assign voltage_uv = volt_q;

endmodule

@@ design/quad_dac_register_shadow.sv @@
// top level of the quad dac register shadow
// depends on qdrs_pkg, qdrs_front, qdrs_queue, qdrs_back and the macro header
//
// usage:
// - command channel (cmd_valid, cmd_stall, func, channel, code, select_bits) takes
//   one decoded dac command per item; taken when cmd_valid is high and cmd_stall low
// - report channel (rpt_valid, rpt_stall and the report fields) gives one item per
//   affected channel; code writes and ignored commands give one, the reference,
//   gain and power-down commands give four in channel order a to d, last on d
// - apb port holds ext_vref_uv at byte address 0; write only while idle
// - the first report passes the queue, the multiply stage and the output register,
//   in that order, before it is valid
// - code writes give one item per cycle while the report queue is not full; a global
//   command holds the command channel while the front end emits its four reports
//   into the report queue, one per cycle while the queue is not full
// - voltage uses one 12 x 23 multiplier in the back end, registered before
//   the output register
// - reset clears all codes and settings and loads 3300000 uv as reference
// - a stalled report holds; the queue fills and then cmd_stall rises
`include "quad_dac_register_shadow_defines.svh"

module quad_dac_register_shadow #(
	parameter int QUEUE_DEPTH = qdrs_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration port
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [qdrs_pkg::ADDR_W-1:0]   paddr,
	input  logic [qdrs_pkg::DATA_W-1:0]   pwdata,
	output logic [qdrs_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	// command channel
	input  logic                          cmd_valid,
	output logic                          cmd_stall,
	input  logic [qdrs_pkg::FUNC_W-1:0]   func,
	input  logic [qdrs_pkg::CH_W-1:0]     channel,
	input  logic [qdrs_pkg::CODE_W-1:0]   code,
	input  logic [qdrs_pkg::SEL_W-1:0]    select_bits,
	// report channel
	output logic                          rpt_valid,
	input  logic                          rpt_stall,
	output logic [qdrs_pkg::CH_W-1:0]     out_channel,
	output logic                          vref_internal,
	output logic [qdrs_pkg::PD_W-1:0]     power_down,
	output logic                          gain_two,
	output logic [qdrs_pkg::CODE_W-1:0]   out_code,
	output logic [qdrs_pkg::CODE_W-1:0]   eeprom_code,
	output logic [qdrs_pkg::VOLT_W-1:0]   voltage_uv,
	output logic                          ignored,
	output logic                          last
);

	logic [qdrs_pkg::VOLT_W-1:0] ext_vref_q;
	logic [0:0] reg_idx;
	logic q_full, q_push, q_pop, q_nonempty;
	qdrs_pkg::report_t q_wdata, q_rdata, rpt;

	// register index is the word address
	assign reg_idx = paddr[qdrs_pkg::ADDR_W-1 -: 1];
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_vref_q <= qdrs_pkg::VREF_RESET_UV;
		end else if (psel && penable && pwrite && reg_idx == qdrs_pkg::REG_EXT_VREF) begin
			ext_vref_q <= pwdata[qdrs_pkg::VOLT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == qdrs_pkg::REG_EXT_VREF) begin
			prdata = qdrs_pkg::DATA_W'(ext_vref_q);
		end
	end

	// front end: decode, update state, expand into per-channel reports
	qdrs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.func        (func),
		.channel     (channel),
		.code        (code),
		.select_bits (select_bits),
		.q_full      (q_full),
		.push        (q_push),
		.entry       (q_wdata)
	);

	// snapshot queue, decouples the front end from output stalls
	qdrs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wdata    (q_wdata),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.rdata    (q_rdata)
	);

	// back end: voltage computation and output register
	qdrs_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.ext_vref_uv (ext_vref_q),
		.q_nonempty  (q_nonempty),
		.head        (q_rdata),
		.pop         (q_pop),
		.rpt_valid   (rpt_valid),
		.rpt_stall   (rpt_stall),
		.rpt         (rpt),
		.voltage_uv  (voltage_uv)
	);

	assign out_channel = rpt.channel;
	assign vref_internal = rpt.settings.vref_int;
	assign power_down = rpt.settings.pd;
	assign gain_two = rpt.settings.gain;
	assign out_code = rpt.code;
	assign eeprom_code = rpt.ecode;
	assign ignored = rpt.ignored;
	assign last = rpt.last;

	// an ignored command always reports a single item
	`QDRS_ASSERT_IMPL(a_ignored_last, rpt_valid && ignored, last, "ignored report without last")

endmodule

@@ verif/qdrs_mirror_pkg.sv @@
// scoreboard for the quad dac register shadow: a mirror of the dac registers that
// predicts every report item and checks the ones the block gives; depends on qdrs_pkg
`timescale 1ns / 1ps

package qdrs_mirror_pkg;
	import qdrs_pkg::*;

	// func codes beyond the named ones, handled like the ignored command
	localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd6;
	localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

	typedef struct packed {
		logic [CH_W-1:0]   channel;
		logic              vref_int;
		logic [PD_W-1:0]   pd;
		logic              gain;
		logic [CODE_W-1:0] code;
		logic [CODE_W-1:0] ecode;
		logic [VOLT_W-1:0] volts;
		logic              ignored;
		logic              last;
	} dac_report_t;

	class dac_register_mirror;
		logic [VOLT_W-1:0] ext_vref_uv;
		settings_t         live_set[NUM_CH];
		logic [CODE_W-1:0] live_code[NUM_CH];
		settings_t         stored_set[NUM_CH];
		logic [CODE_W-1:0] stored_code[NUM_CH];
		dac_report_t       pending_reports[$];
		int unsigned       failures;

		function new();
			ext_vref_uv = VREF_RESET_UV;
			failures = 0;
			for (int i = 0; i < NUM_CH; i++) begin
				live_set[i] = '0;
				live_code[i] = '0;
				stored_set[i] = '0;
				stored_code[i] = '0;
			end
		endfunction

		function void set_ext_vref(logic [DATA_W-1:0] data);
			ext_vref_uv = data[VOLT_W-1:0];
		endfunction

		function int unsigned pending();
			return pending_reports.size();
		endfunction

		// output voltage of one channel from its live settings and code
		function logic [VOLT_W-1:0] channel_volts(int ch);
			longint unsigned prod;
			if (live_set[ch].pd != '0)
				return '0;
			if (!live_set[ch].vref_int) begin
				prod = longint'(live_code[ch]) * longint'(ext_vref_uv);
				return VOLT_W'(prod >> CODE_W);
			end
			prod = longint'(live_code[ch]) * longint'(INT_LSB_UV) * (live_set[ch].gain ? 2 : 1);
			return VOLT_W'(prod);
		endfunction

		function void push_report(int ch, logic ign, logic fin);
			dac_report_t r;
			r.channel = CH_W'(ch);
			r.vref_int = live_set[ch].vref_int;
			r.pd = live_set[ch].pd;
			r.gain = live_set[ch].gain;
			r.code = live_code[ch];
			r.ecode = stored_code[ch];
			r.volts = channel_volts(ch);
			r.ignored = ign;
			r.last = fin;
			pending_reports.push_back(r);
		endfunction

		// one accepted command: update the mirror, queue the reports it causes
		function void note_command(logic [FUNC_W-1:0] f, logic [CH_W-1:0] ch,
				logic [CODE_W-1:0] new_code, logic [SEL_W-1:0] sel);
			bit all_channels;
			all_channels = 1'b0;
			case (f)
				FUNC_WRITE_VOL, FUNC_WRITE_EE: begin
					live_code[ch] = new_code;
					if (f == FUNC_WRITE_EE) begin
						stored_code[ch] = new_code;
						stored_set[ch] = live_set[ch];
					end
					push_report(ch, 1'b0, 1'b1);
				end
				FUNC_VREF: begin
					for (int i = 0; i < NUM_CH; i++)
						live_set[i].vref_int = sel[3 - i];
					all_channels = 1'b1;
				end
				FUNC_GAIN: begin
					for (int i = 0; i < NUM_CH; i++)
						live_set[i].gain = sel[3 - i];
					all_channels = 1'b1;
				end
				FUNC_PWRDN: begin
					for (int i = 0; i < NUM_CH; i++)
						live_set[i].pd = sel[(6 - 2 * i) +: PD_W];
					all_channels = 1'b1;
				end
				default: push_report(ch, 1'b1, 1'b1);
			endcase
			if (all_channels)
				for (int i = 0; i < NUM_CH; i++)
					push_report(i, 1'b0, i == NUM_CH - 1);
		endfunction

		function void check_field(string name, longint unsigned want, longint unsigned got);
			if (want != got) begin
				$error("report field %s: expected %0d, got %0d", name, want, got);
				failures++;
			end
		endfunction

		function void check_report(dac_report_t got);
			dac_report_t want;
			if (pending_reports.size() == 0) begin
				$error("report item on channel %0d with none expected", got.channel);
				failures++;
				return;
			end
			want = pending_reports.pop_front();
			check_field("out_channel", want.channel, got.channel);
			check_field("vref_internal", want.vref_int, got.vref_int);
			check_field("power_down", want.pd, got.pd);
			check_field("gain_two", want.gain, got.gain);
			check_field("out_code", want.code, got.code);
			check_field("eeprom_code", want.ecode, got.ecode);
			check_field("voltage_uv", want.volts, got.volts);
			check_field("ignored", want.ignored, got.ignored);
			check_field("last", want.last, got.last);
		endfunction
	endclass

endpackage

@@ verif/quad_dac_register_shadow_test.sv @@
// testbench top of the quad dac register shadow: directed and random dac commands
// under varied idling, every report checked against the register mirror
// depends on qdrs_pkg, qdrs_mirror_pkg and the quad_dac_register_shadow rtl
`timescale 1ns / 1ps

module quad_dac_register_shadow_test;
	import qdrs_pkg::*;
	import qdrs_mirror_pkg::*;

	// generous bound on the whole run in clock cycles
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned ITEMS_PER_PHASE = 24;
	localparam int unsigned DRAIN_CYCLES = 20;
	// ext_vref_uv sits at byte address 4 * its register index
	localparam logic [ADDR_W-1:0] VREF_ADDR = ADDR_W'(4 * REG_EXT_VREF);

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata, prdata;
	logic pready;
	logic cmd_valid, cmd_stall;
	logic [FUNC_W-1:0] func;
	logic [CH_W-1:0] channel;
	logic [CODE_W-1:0] code;
	logic [SEL_W-1:0] select_bits;
	logic rpt_valid, rpt_stall;
	logic [CH_W-1:0] out_channel;
	logic vref_internal;
	logic [PD_W-1:0] power_down;
	logic gain_two;
	logic [CODE_W-1:0] out_code, eeprom_code;
	logic [VOLT_W-1:0] voltage_uv;
	logic ignored, last;

	// idle and stall odds in percent, changed per phase
	int unsigned send_idle_pct;
	int unsigned rpt_stall_pct;

	dac_register_mirror mirror;

	quad_dac_register_shadow dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .func(func),
		.channel(channel), .code(code), .select_bits(select_bits),
		.rpt_valid(rpt_valid), .rpt_stall(rpt_stall), .out_channel(out_channel),
		.vref_internal(vref_internal), .power_down(power_down), .gain_two(gain_two),
		.out_code(out_code), .eeprom_code(eeprom_code), .voltage_uv(voltage_uv),
		.ignored(ignored), .last(last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: a hung handshake ends the run as a failure
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// command monitor: every accepted item goes to the mirror in acceptance order
	always @(posedge clk) begin
		if (arst_n && cmd_valid && !cmd_stall)
			mirror.note_command(func, channel, code, select_bits);
	end

	// report monitor: every accepted report item is checked against the oldest prediction
	always @(posedge clk) begin
		dac_report_t got;
		if (arst_n && rpt_valid && !rpt_stall) begin
			got.channel = out_channel;
			got.vref_int = vref_internal;
			got.pd = power_down;
			got.gain = gain_two;
			got.code = out_code;
			got.ecode = eeprom_code;
			got.volts = voltage_uv;
			got.ignored = ignored;
			got.last = last;
			mirror.check_report(got);
		end
	end

	// receiver side: stall decided anew at each falling edge
	always @(negedge clk) begin
		rpt_stall = (rpt_stall_pct != 0) && ($urandom_range(0, 99) < rpt_stall_pct);
	end

	// one apb write of ext_vref_uv followed by a read back of the same register;
	// the bits above the 23-bit field carry noise and must be dropped by the block
	task automatic write_ext_vref(input logic [VOLT_W-1:0] uv);
		logic [DATA_W-1:0] rd;
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = VREF_ADDR;
		pwdata = {(DATA_W - VOLT_W)'($urandom), uv};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		mirror.set_ext_vref(pwdata);
		@(negedge clk);
		// read setup right after the write
		pwrite = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		if (rd[VOLT_W-1:0] != uv) begin
			$error("readback ext_vref_uv: expected %0d, got %0d", uv, rd[VOLT_W-1:0]);
			mirror.failures++;
		end
	endtask

	// present one command and hold it until taken; called and left at a falling edge
	task automatic send_command(input logic [FUNC_W-1:0] f, input logic [CH_W-1:0] ch,
			input logic [CODE_W-1:0] c, input logic [SEL_W-1:0] sel);
		while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			cmd_valid = 1'b0;
			@(negedge clk);
		end
		cmd_valid = 1'b1;
		func = f;
		channel = ch;
		code = c;
		select_bits = sel;
		do @(posedge clk); while (cmd_stall);
		@(negedge clk);
	endtask

	// random command, mostly code writes and global commands with random content
	task automatic send_random_command();
		int unsigned pick;
		int unsigned code_pick;
		logic [FUNC_W-1:0] f;
		logic [CODE_W-1:0] c;
		logic [SEL_W-1:0] sel;
		pick = $urandom_range(0, 99);
		code_pick = $urandom_range(0, 9);
		sel = SEL_W'($urandom);
		if (pick < 25)
			f = FUNC_WRITE_VOL;
		else if (pick < 50)
			f = FUNC_WRITE_EE;
		else if (pick < 63)
			f = FUNC_VREF;
		else if (pick < 76)
			f = FUNC_GAIN;
		else if (pick < 90) begin
			f = FUNC_PWRDN;
			// keep channels powered on often enough to see voltages
			if ($urandom_range(0, 1) == 0)
				sel = '0;
		end else
			f = FUNC_W'($urandom_range(FUNC_IGNORE, FUNC_SPARE_HI));
		if (code_pick == 0)
			c = '0;
		else if (code_pick == 1)
			c = '1;
		else
			c = CODE_W'($urandom);
		send_command(f, CH_W'($urandom_range(0, NUM_CH - 1)), c, sel);
	endtask

	// stop presenting and wait until every predicted report has come back
	task automatic drain_reports();
		cmd_valid = 1'b0;
		while (mirror.pending() != 0)
			@(negedge clk);
	endtask

	initial begin
		logic [VOLT_W-1:0] phase_vref[4];
		int unsigned phase_idle[4];
		int unsigned phase_stall[4];

		mirror = new();
		send_idle_pct = 0;
		rpt_stall_pct = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cmd_valid = 1'b0;
		func = FUNC_WRITE_VOL;
		channel = '0;
		code = '0;
		select_bits = '0;
		rpt_stall = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed part at the reset reference, no idling
		// full-scale and zero codes on the external reference
		send_command(FUNC_WRITE_VOL, 2'd0, 12'hFFF, 8'hFF);
		send_command(FUNC_WRITE_EE, 2'd1, 12'hFFF, 8'h00);
		send_command(FUNC_WRITE_EE, 2'd2, 12'h000, 8'hA5);
		send_command(FUNC_WRITE_VOL, 2'd3, 12'h800, 8'h5A);
		// high select nibble is not used by the reference and gain commands
		send_command(FUNC_VREF, 2'd3, 12'hFFF, 8'hF0);
		send_command(FUNC_VREF, 2'd0, 12'h000, 8'h0A);
		send_command(FUNC_GAIN, 2'd1, 12'h123, 8'hF5);
		// mixed power-down modes: a off mode 3, b on, c mode 1, d mode 2
		send_command(FUNC_PWRDN, 2'd2, 12'hABC, 8'hC6);
		// eeprom write while powered down copies the live settings
		send_command(FUNC_WRITE_EE, 2'd0, 12'h7FF, 8'h00);
		send_command(FUNC_WRITE_EE, 2'd3, 12'hFFF, 8'hFF);
		// ignored and undefined commands change nothing
		send_command(FUNC_IGNORE, 2'd0, 12'hFFF, 8'hFF);
		send_command(FUNC_SPARE_LO, 2'd3, 12'h000, 8'h00);
		send_command(FUNC_SPARE_HI, 2'd2, 12'h555, 8'hAA);
		send_command(FUNC_PWRDN, 2'd0, 12'h000, 8'h00);
		// internal reference with gain two on every channel, full-scale codes on a and b, lowest code on c
		send_command(FUNC_VREF, 2'd0, 12'h000, 8'hFF);
		send_command(FUNC_GAIN, 2'd0, 12'h000, 8'hFF);
		send_command(FUNC_WRITE_VOL, 2'd0, 12'hFFF, 8'h00);
		send_command(FUNC_WRITE_VOL, 2'd1, 12'hFFF, 8'h00);
		send_command(FUNC_WRITE_VOL, 2'd2, 12'h001, 8'h00);
		send_command(FUNC_GAIN, 2'd0, 12'h000, 8'h00);
		send_command(FUNC_PWRDN, 2'd1, 12'hFFF, 8'hFF);
		send_command(FUNC_VREF, 2'd0, 12'h000, 8'h00);
		send_command(FUNC_PWRDN, 2'd0, 12'h000, 8'h00);
		send_command(FUNC_IGNORE, 2'd1, 12'h000, 8'h00);
		drain_reports();

		// random phases: reference extremes and one random reference, each with its own idling and stall pattern
		phase_vref[0] = 23'd5500000;
		phase_vref[1] = '0;
		phase_vref[2] = '1;
		phase_vref[3] = VOLT_W'($urandom_range(1, 5500000));
		phase_idle[0] = 0;
		phase_stall[0] = 0;
		phase_idle[1] = 45;
		phase_stall[1] = 0;
		phase_idle[2] = 0;
		phase_stall[2] = 45;
		phase_idle[3] = 30;
		phase_stall[3] = 30;
		for (int p = 0; p < 4; p++) begin
			// block is idle here: every report of the earlier phase has arrived
			write_ext_vref(phase_vref[p]);
			send_idle_pct = phase_idle[p];
			rpt_stall_pct = phase_stall[p];
			for (int n = 0; n < ITEMS_PER_PHASE; n++)
				send_random_command();
			drain_reports();
		end

		// a few more cycles to catch any report item beyond the predicted ones
		rpt_stall_pct = 0;
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mirror.failures == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+design
design/qdrs_pkg.sv
design/qdrs_front.sv
design/qdrs_queue.sv
design/qdrs_back.sv
design/quad_dac_register_shadow.sv
verif/qdrs_mirror_pkg.sv
verif/quad_dac_register_shadow_test.sv
